/* design/rc_channel_latch_and_scale_unit_macros.svh */
// Assertion macros used by the checker file of the RC channel latch and scale unit.
`ifndef RC_CHANNEL_LATCH_AND_SCALE_UNIT_MACROS_SVH
`define RC_CHANNEL_LATCH_AND_SCALE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rstn is low.
`define RCLS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcls assertion failed");

// Next-cycle implication, disabled while rstn is low.
`define RCLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcls assertion failed");

`endif

/* design/rcls_pkg.sv */
// Shared types and constants of the RC channel latch and scale unit.
package rcls_pkg;

    localparam int CHANNEL_COUNT_DEF = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE_LOW   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_HIGH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_INDEX = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAL_CODE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VALID_CODE = 3'd4;

    localparam logic [15:0] MODE_LOW_RST   = 16'd1300;
    localparam logic [15:0] MODE_HIGH_RST  = 16'd1700;
    localparam logic [3:0]  MODE_INDEX_RST = 4'd5;
    localparam logic [15:0] QUAL_CODE_RST  = 16'd0;
    localparam logic [15:0] VALID_CODE_RST = 16'd1;

    localparam logic [1:0] ACT_AXIS = 2'd0;
    localparam logic [1:0] ACT_MISC = 2'd1;

    localparam logic signed [31:0] CENTER_US = 32'sd1500;
    localparam logic signed [31:0] MIN_US    = 32'sd1000;
    localparam logic signed [31:0] MAX_US    = 32'sd2000;
    localparam int THROTTLE_INDEX = 2;
    localparam int ARM_INDEX      = 4;

    localparam logic signed [10:0] MILLI_MIN  = -11'sd1000;
    localparam logic signed [10:0] MILLI_MAX  = 11'sd1000;
    localparam logic [9:0]         THRUST_MAX = 10'd1000;

    typedef enum logic [1:0] {
        MODE_ACRO = 2'd0,
        MODE_MID  = 2'd1,
        MODE_POS  = 2'd2
    } fmode_t;

endpackage

/* design/rc_channel_latch_and_scale_unit.sv */
// Top level of the RC channel latch and scale unit: staged channels, scaling, result register.
//
// Receiver events enter on the s_ channel (valid/ready). Axis events write a staged
// channel, misc events update link quality or frame validity. An event with
// s_frame_sync set applies its own update and then produces one manual-control
// transfer on the m_ channel, computed from the staged frame.
// An event is captured in an input register, its update and the scaling run in one
// pass of combinational logic, and a sync event's result is then loaded into the
// result register once that register is free, and transfers out from there.
// Throughput: one event per cycle while no sync event waits, set by the single input
// stage feeding the output register; non-sync events retire without touching the output side.
// When the receiver stalls, the output register holds its result; the input
// stage keeps draining non-sync events and only a sync event waits behind it.
// Reset (aresetn low, synchronous) empties both stages, restores all staged
// channels to 1500 us (throttle 1000 us), clears validity and link quality and
// loads the configuration defaults. The user must write configuration through cfg_we,
// cfg_addr and cfg_wdata only while the block is idle; the block does not enforce this.
module rc_channel_latch_and_scale_unit #(
    parameter int CHANNEL_COUNT = rcls_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [rcls_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rcls_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_action,
    input  logic [15:0]                     s_event_code,
    input  logic signed [31:0]              s_event_value,
    input  logic                            s_frame_sync,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [10:0]              m_roll_cmd,
    output logic signed [10:0]              m_pitch_cmd,
    output logic [9:0]                      m_throttle_cmd,
    output logic signed [10:0]              m_yaw_cmd,
    output logic [1:0]                      m_fly_mode,
    output logic                            m_frame_valid,
    output logic                            m_frame_active,
    output logic                            m_arm_switch,
    output logic [7:0]                      m_link_quality
);

    function automatic logic signed [10:0] center_scale(input logic signed [31:0] v);
        logic signed [32:0] d;
        begin
            d = $signed({v[31], v}) - $signed({rcls_pkg::CENTER_US[31], rcls_pkg::CENTER_US});
            if (v < rcls_pkg::MIN_US) begin
                return rcls_pkg::MILLI_MIN;
            end else if (v > rcls_pkg::MAX_US) begin
                return rcls_pkg::MILLI_MAX;
            end
            return $signed({d[9:0], 1'b0});
        end
    endfunction

    // configuration registers
    logic [15:0] mode_low_reg, mode_high_reg, qual_code_reg, valid_code_reg;
    logic [3:0]  mode_index_reg;

    // staged frame
    logic signed [31:0] chan_reg [CHANNEL_COUNT];
    logic signed [31:0] chan_next [CHANNEL_COUNT];
    logic               stvalid_reg, stvalid_next;
    logic [7:0]         quality_reg, quality_next;

    // input stage
    logic               in_valid_reg;
    logic [1:0]         in_action_reg;
    logic [15:0]        in_code_reg;
    logic signed [31:0] in_value_reg;
    logic               in_sync_reg;

    // output stage
    logic               out_valid_reg;
    logic signed [10:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [10:0] roll_next, pitch_next, yaw_next;
    logic [9:0]         throttle_reg, throttle_next;
    logic [1:0]         mode_reg;
    rcls_pkg::fmode_t   mode_next;
    logic               fvalid_reg, arm_reg, arm_next;
    logic [7:0]         lq_reg;

    logic               out_free, in_advance, out_load;
    logic signed [31:0] mode_sel;
    logic signed [31:0] thr_ch;

    assign out_free   = !out_valid_reg || m_ready;
    assign in_advance = in_valid_reg && (!in_sync_reg || out_free);
    assign out_load   = in_advance && in_sync_reg;
    assign s_ready    = !in_valid_reg || in_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_low_reg   <= rcls_pkg::MODE_LOW_RST;
            mode_high_reg  <= rcls_pkg::MODE_HIGH_RST;
            mode_index_reg <= rcls_pkg::MODE_INDEX_RST;
            qual_code_reg  <= rcls_pkg::QUAL_CODE_RST;
            valid_code_reg <= rcls_pkg::VALID_CODE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                rcls_pkg::REG_MODE_LOW:   mode_low_reg   <= cfg_wdata;
                rcls_pkg::REG_MODE_HIGH:  mode_high_reg  <= cfg_wdata;
                rcls_pkg::REG_MODE_INDEX: mode_index_reg <= cfg_wdata[3:0];
                rcls_pkg::REG_QUAL_CODE:  qual_code_reg  <= cfg_wdata;
                rcls_pkg::REG_VALID_CODE: valid_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_code_reg   <= s_event_code;
            in_value_reg  <= s_event_value;
            in_sync_reg   <= s_frame_sync;
        end
    end

    // apply the event's update to the staged frame
    always_comb begin
        stvalid_next = stvalid_reg;
        quality_next = quality_reg;
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
            chan_next[k] = chan_reg[k];
            if (in_action_reg == rcls_pkg::ACT_AXIS && in_code_reg == 16'(k + 1)) begin
                chan_next[k] = in_value_reg;
                stvalid_next = 1'b1;
            end
        end
        if (in_action_reg == rcls_pkg::ACT_MISC) begin
            if (in_code_reg == qual_code_reg) begin
                quality_next = in_value_reg[7:0];
            end else if (in_code_reg == valid_code_reg) begin
                stvalid_next = (in_value_reg != 32'sd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                chan_reg[k] <= (k == rcls_pkg::THROTTLE_INDEX) ? rcls_pkg::MIN_US
                                                               : rcls_pkg::CENTER_US;
            end
            stvalid_reg <= 1'b0;
            quality_reg <= 8'd0;
        end else if (in_advance) begin
            for (int k = 0; k < CHANNEL_COUNT; k++) begin
                chan_reg[k] <= chan_next[k];
            end
            stvalid_reg <= stvalid_next;
            quality_reg <= quality_next;
        end
    end

    // scale the updated frame
    always_comb begin
        mode_sel = rcls_pkg::CENTER_US;
        for (int k = 0; k < CHANNEL_COUNT; k++) begin
            if (32'(mode_index_reg) == k) begin
                mode_sel = chan_next[k];
            end
        end
        if (32'(mode_index_reg) >= CHANNEL_COUNT) begin
            mode_next = rcls_pkg::MODE_ACRO;
        end else if ($signed({mode_sel[31], mode_sel}) < $signed({17'd0, mode_low_reg})) begin
            mode_next = rcls_pkg::MODE_ACRO;
        end else if ($signed({mode_sel[31], mode_sel}) < $signed({17'd0, mode_high_reg})) begin
            mode_next = rcls_pkg::MODE_MID;
        end else begin
            mode_next = rcls_pkg::MODE_POS;
        end

        roll_next  = center_scale(chan_next[0]);
        pitch_next = center_scale(chan_next[1]);
        yaw_next   = 11'sd0 - center_scale(chan_next[3]);

        thr_ch = chan_next[rcls_pkg::THROTTLE_INDEX];
        if (thr_ch < rcls_pkg::MIN_US) begin
            throttle_next = 10'd0;
        end else if (thr_ch > rcls_pkg::MAX_US) begin
            throttle_next = rcls_pkg::THRUST_MAX;
        end else begin
            throttle_next = thr_ch[9:0] - rcls_pkg::MIN_US[9:0];
        end

        arm_next = (chan_next[rcls_pkg::ARM_INDEX] >= rcls_pkg::CENTER_US);
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            roll_reg     <= roll_next;
            pitch_reg    <= pitch_next;
            throttle_reg <= throttle_next;
            yaw_reg      <= yaw_next;
            mode_reg     <= mode_next;
            fvalid_reg   <= stvalid_next;
            arm_reg      <= arm_next;
            lq_reg       <= quality_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_roll_cmd     = roll_reg;
    assign m_pitch_cmd    = pitch_reg;
    assign m_throttle_cmd = throttle_reg;
    assign m_yaw_cmd      = yaw_reg;
    assign m_fly_mode     = mode_reg;
    assign m_frame_valid  = fvalid_reg;
    assign m_frame_active = fvalid_reg;
    assign m_arm_switch   = arm_reg;
    assign m_link_quality = lq_reg;

endmodule

/* design/rcls_checker.sv */
// Port-level checker for the RC channel latch and scale unit, with its bind.
`include "rc_channel_latch_and_scale_unit_macros.svh"

module rcls_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_frame_sync,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [10:0] m_roll_cmd,
    input logic signed [10:0] m_pitch_cmd,
    input logic [9:0]         m_throttle_cmd,
    input logic signed [10:0] m_yaw_cmd,
    input logic [1:0]         m_fly_mode,
    input logic               m_frame_valid,
    input logic               m_frame_active,
    input logic               m_arm_switch,
    input logic [7:0]         m_link_quality
);

    logic [55:0] m_payload;

    assign m_payload = {m_roll_cmd, m_pitch_cmd, m_throttle_cmd, m_yaw_cmd, m_fly_mode,
                        m_frame_valid, m_frame_active, m_arm_switch, m_link_quality};

    // a stalled result holds
    `RCLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // reset empties the result register
    `RCLS_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid)

    // a sync transfer is followed by a result on the output
    `RCLS_ASSERT_NEXT(a_sync_result, aclk, aresetn, s_valid && s_ready && s_frame_sync, ##1 m_valid)

    // active flag follows validity and the fly mode is a defined value
    `RCLS_ASSERT_IMPL(a_active_eq, aclk, aresetn, m_valid, m_frame_active == m_frame_valid && m_fly_mode != 2'd3)

endmodule

bind rc_channel_latch_and_scale_unit rcls_checker u_rcls_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_frame_sync   (s_frame_sync),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_roll_cmd     (m_roll_cmd),
    .m_pitch_cmd    (m_pitch_cmd),
    .m_throttle_cmd (m_throttle_cmd),
    .m_yaw_cmd      (m_yaw_cmd),
    .m_fly_mode     (m_fly_mode),
    .m_frame_valid  (m_frame_valid),
    .m_frame_active (m_frame_active),
    .m_arm_switch   (m_arm_switch),
    .m_link_quality (m_link_quality)
);
